// ----- rtl/tmq_pkg.sv -----
// Typed message queue: shared constants, status codes and the structs
// that join the controller and the datapath. No dependencies.
package tmq_pkg;

  localparam int SLOTS      = 64;
  localparam int MSG_BYTES  = 64;

  localparam int TYPE_W     = 31;
  localparam int LEN_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int SEL_W      = 32;
  localparam int ST_W       = 3;
  localparam int HI_W       = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int BODY_DEPTH = SLOTS * MSG_BYTES;
  localparam int BODY_AW    = $clog2(BODY_DEPTH);

  // Result status codes
  localparam logic [ST_W-1:0] ST_DATA    = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOMATCH = 3'd2;
  localparam logic [ST_W-1:0] ST_STORED  = 3'd3;
  localparam logic [ST_W-1:0] ST_DROPPED = 3'd4;

  // Input command codes
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  // One header entry
  typedef struct packed {
    logic [TYPE_W-1:0] mtype;
    logic [LEN_W-1:0]  len;
    logic [HI_W-1:0]   body;
  } hdr_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic in_take;
    logic hdr_rd_send;
    logic body_latch;
    logic byte_wr;
    logic send_done;
    logic scan_init;
    logic hdr_rd_idx;
    logic scan_next;
    logic hit_latch;
    logic res_nomatch;
    logic res_empty;
    logic body_rd;
    logic res_byte;
    logic hdr_rd_next;
    logic sh_wr;
    logic sh_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_cmd;
    logic busy;
    logic full;
    logic used_zero;
    logic send_last;
    logic match;
    logic scan_end;
    logic n_zero;
    logic out_free;
    logic byte_end;
    logic sh_end;
  } sts_t;

endpackage

// ----- rtl/tmq_if.sv -----
// Typed message queue: input and result channel interfaces.
// Depends on tmq_pkg for field widths.
interface tmq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [tmq_pkg::TYPE_W-1:0]       send_type;
  logic [tmq_pkg::BYTE_W-1:0]       data_byte;
  logic                             byte_valid;
  logic                             last;
  logic signed [tmq_pkg::SEL_W-1:0] request_type;
  logic [tmq_pkg::LEN_W-1:0]        buffer_len;

  modport source (output valid, command, send_type, data_byte, byte_valid, last,
                  request_type, buffer_len, input ready);
  modport sink   (input valid, command, send_type, data_byte, byte_valid, last,
                  request_type, buffer_len, output ready);
endinterface

interface tmq_out_if;
  logic                       valid;
  logic                       ready;
  logic [tmq_pkg::ST_W-1:0]   status;
  logic [tmq_pkg::TYPE_W-1:0] msg_type;
  logic [tmq_pkg::LEN_W-1:0]  length;
  logic [tmq_pkg::BYTE_W-1:0] out_byte;
  logic                       last_res;

  modport source (output valid, status, msg_type, length, out_byte, last_res,
                  input ready);
  modport sink   (input valid, status, msg_type, length, out_byte, last_res,
                  output ready);
endinterface

// ----- rtl/tmq_ram.sv -----
// Typed message queue: generic single-write, single-read RAM with
// registered read data. No dependencies.
module tmq_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tmq_ctrl.sv -----
// Typed message queue: controller state machine for send items and the
// receive scan, delivery and header shift. Depends on tmq_pkg.
module tmq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tmq_pkg::sts_t sts_i,
  output tmq_pkg::cmd_t cmd_o
);

  localparam logic [3:0] IDLE   = 4'd0;
  localparam logic [3:0] S_HRD  = 4'd1;
  localparam logic [3:0] S_HLAT = 4'd2;
  localparam logic [3:0] S_BYTE = 4'd3;
  localparam logic [3:0] S_RES  = 4'd4;
  localparam logic [3:0] R_RD   = 4'd5;
  localparam logic [3:0] R_CMP  = 4'd6;
  localparam logic [3:0] R_SEL  = 4'd7;
  localparam logic [3:0] R_NOM  = 4'd8;
  localparam logic [3:0] R_EMP  = 4'd9;
  localparam logic [3:0] R_DRD  = 4'd10;
  localparam logic [3:0] R_DOUT = 4'd11;
  localparam logic [3:0] SH_RD  = 4'd12;
  localparam logic [3:0] SH_WR  = 4'd13;

  logic [3:0] state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.in_take = 1'b1;
          if (sts_i.in_cmd == tmq_pkg::CMD_RECV) begin
            if (sts_i.used_zero) begin
              state_d = R_NOM;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d = R_RD;
            end
          end else if (!sts_i.busy && !sts_i.full) begin
            state_d = S_HRD;
          end else begin
            state_d = S_BYTE;
          end
        end
      end
      S_HRD: begin
        cmd_o.hdr_rd_send = 1'b1;
        state_d = S_HLAT;
      end
      S_HLAT: begin
        cmd_o.body_latch = 1'b1;
        state_d = S_BYTE;
      end
      S_BYTE: begin
        cmd_o.byte_wr = 1'b1;
        state_d = sts_i.send_last ? S_RES : IDLE;
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.send_done = 1'b1;
          state_d = IDLE;
        end
      end
      R_RD: begin
        cmd_o.hdr_rd_idx = 1'b1;
        state_d = R_CMP;
      end
      R_CMP: begin
        if (sts_i.match) begin
          cmd_o.hit_latch = 1'b1;
          state_d = R_SEL;
        end else if (sts_i.scan_end) begin
          state_d = R_NOM;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = R_RD;
        end
      end
      R_SEL: begin
        state_d = sts_i.n_zero ? R_EMP : R_DRD;
      end
      R_NOM: begin
        if (sts_i.out_free) begin
          cmd_o.res_nomatch = 1'b1;
          state_d = IDLE;
        end
      end
      R_EMP: begin
        if (sts_i.out_free) begin
          cmd_o.res_empty = 1'b1;
          state_d = SH_RD;
        end
      end
      R_DRD: begin
        cmd_o.body_rd = 1'b1;
        state_d = R_DOUT;
      end
      R_DOUT: begin
        if (sts_i.out_free) begin
          cmd_o.res_byte = 1'b1;
          state_d = sts_i.byte_end ? SH_RD : R_DRD;
        end
      end
      SH_RD: begin
        if (sts_i.sh_end) begin
          cmd_o.sh_last = 1'b1;
          state_d = IDLE;
        end else begin
          cmd_o.hdr_rd_next = 1'b1;
          state_d = SH_WR;
        end
      end
      SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d = SH_RD;
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/tmq_dp.sv -----
// Typed message queue: datapath with header and body RAMs, send and
// receive registers and the result register. Depends on tmq_pkg, tmq_if, tmq_ram.
module tmq_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  tmq_in_if.sink        in_i,
  tmq_out_if.source     out_o,
  input  tmq_pkg::cmd_t cmd_i,
  output tmq_pkg::sts_t sts_o
);

  localparam int HW = $bits(tmq_pkg::hdr_t);

  // Control registers
  logic [tmq_pkg::CNT_W-1:0] used_q;
  logic                      busy_q;
  logic [tmq_pkg::SLOTS-1:0] hval_bits_q;
  logic                      out_valid_q;

  // Payload registers
  logic                              drop_q;
  logic [tmq_pkg::LEN_W-1:0]         scnt_q;
  logic [tmq_pkg::TYPE_W-1:0]        stype_q;
  logic [tmq_pkg::HI_W-1:0]          sbody_q;
  logic [tmq_pkg::BYTE_W-1:0]        dbyte_q;
  logic                              bval_q;
  logic                              last_q;
  logic signed [tmq_pkg::SEL_W-1:0]  sel_q;
  logic [tmq_pkg::LEN_W-1:0]         cap_q;
  logic [tmq_pkg::HI_W-1:0]          idx_q;
  logic [tmq_pkg::TYPE_W-1:0]        mtype_q;
  logic [tmq_pkg::LEN_W-1:0]         mlen_q;
  logic [tmq_pkg::HI_W-1:0]          mbody_q;
  logic [tmq_pkg::LEN_W-1:0]         bidx_q;
  logic [tmq_pkg::HI_W-1:0]          hraddr_q;
  logic                              hval_q;
  logic [tmq_pkg::ST_W-1:0]          ost_q;
  logic [tmq_pkg::TYPE_W-1:0]        otype_q;
  logic [tmq_pkg::LEN_W-1:0]         olen_q;
  logic [tmq_pkg::BYTE_W-1:0]        obyte_q;
  logic                              olast_q;

  // RAM ports
  logic                        h_we, h_re;
  logic [tmq_pkg::HI_W-1:0]    h_waddr, h_raddr;
  tmq_pkg::hdr_t               h_wdata, hrd;
  logic [HW-1:0]               h_rdata;
  logic                        b_we, b_re;
  logic [tmq_pkg::BODY_AW-1:0] b_waddr, b_raddr;
  logic [tmq_pkg::BYTE_W-1:0]  b_rdata;

  logic                        full, out_free, out_load, match, byte_end, room;
  logic [tmq_pkg::SEL_W-1:0]   mag;
  logic [tmq_pkg::LEN_W-1:0]   n_cur;
  logic [tmq_pkg::HI_W-1:0]    body_eff;

  assign hrd      = tmq_pkg::hdr_t'(h_rdata);
  assign full     = (used_q == tmq_pkg::CNT_W'(tmq_pkg::SLOTS));
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = cmd_i.send_done || cmd_i.res_nomatch || cmd_i.res_empty ||
                    cmd_i.res_byte;
  assign byte_end = (bidx_q + 1'b1 == mlen_q);
  assign room     = (scnt_q < tmq_pkg::LEN_W'(tmq_pkg::MSG_BYTES));
  // A header never written keeps its initial body slot, its own index
  assign body_eff = hval_q ? hrd.body : hraddr_q;

  // Type selector: positive exact, negative up to magnitude, zero any
  assign mag   = $unsigned(-sel_q);
  assign match = (sel_q == '0) ||
                 (sel_q[tmq_pkg::SEL_W-1] ? ({1'b0, hrd.mtype} <= mag)
                                          : ({1'b0, hrd.mtype} == $unsigned(sel_q)));
  assign n_cur = (hrd.len < cap_q) ? hrd.len : cap_q;

  // Header RAM addressing
  always_comb begin
    h_re    = cmd_i.hdr_rd_send || cmd_i.hdr_rd_idx || cmd_i.hdr_rd_next;
    h_raddr = idx_q;
    if (cmd_i.hdr_rd_send) begin
      h_raddr = used_q[tmq_pkg::HI_W-1:0];
    end else if (cmd_i.hdr_rd_next) begin
      h_raddr = idx_q + 1'b1;
    end
    h_we    = 1'b0;
    h_waddr = idx_q;
    h_wdata = '{mtype: hrd.mtype, len: hrd.len, body: body_eff};
    if (cmd_i.send_done && !drop_q) begin
      h_we    = 1'b1;
      h_waddr = used_q[tmq_pkg::HI_W-1:0];
      h_wdata = '{mtype: stype_q, len: scnt_q, body: sbody_q};
    end else if (cmd_i.sh_wr) begin
      h_we    = 1'b1;
    end else if (cmd_i.sh_last) begin
      h_we    = 1'b1;
      h_waddr = tmq_pkg::HI_W'(tmq_pkg::SLOTS - 1);
      h_wdata = '{mtype: '0, len: '0, body: mbody_q};
    end
  end

  // Body RAM addressing
  assign b_we    = cmd_i.byte_wr && bval_q && room && !drop_q;
  assign b_waddr = tmq_pkg::BODY_AW'(sbody_q) * tmq_pkg::BODY_AW'(tmq_pkg::MSG_BYTES) +
                   tmq_pkg::BODY_AW'(scnt_q);
  assign b_re    = cmd_i.body_rd;
  assign b_raddr = tmq_pkg::BODY_AW'(mbody_q) * tmq_pkg::BODY_AW'(tmq_pkg::MSG_BYTES) +
                   tmq_pkg::BODY_AW'(bidx_q);

  tmq_ram #(.W(HW), .DEPTH(tmq_pkg::SLOTS)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (HW'(h_wdata)),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  tmq_ram #(.W(tmq_pkg::BYTE_W), .DEPTH(tmq_pkg::BODY_DEPTH)) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (dbyte_q),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Control state: fill count, send flag, header written bits, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      busy_q      <= 1'b0;
      hval_bits_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.in_take && in_i.command == tmq_pkg::CMD_SEND) begin
        busy_q <= 1'b1;
      end else if (cmd_i.send_done) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.send_done && !drop_q) begin
        used_q <= used_q + 1'b1;
      end else if (cmd_i.sh_last) begin
        used_q <= used_q - 1'b1;
      end
      if (h_we) begin
        hval_bits_q[h_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item fields and send progress
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      dbyte_q <= in_i.data_byte;
      bval_q  <= in_i.byte_valid;
      last_q  <= in_i.last;
      sel_q   <= in_i.request_type;
      cap_q   <= in_i.buffer_len;
      if (in_i.command == tmq_pkg::CMD_SEND && !busy_q) begin
        stype_q <= in_i.send_type;
        scnt_q  <= '0;
        drop_q  <= full;
      end
    end
    if (cmd_i.body_latch) begin
      sbody_q <= body_eff;
    end
    if (cmd_i.byte_wr && bval_q && room) begin
      scnt_q <= scnt_q + 1'b1;
    end
  end

  // Receive scan, delivery and shift registers
  always_ff @(posedge clk_i) begin
    if (h_re) begin
      hraddr_q <= h_raddr;
      hval_q   <= hval_bits_q[h_raddr];
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.scan_next || cmd_i.sh_wr) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.hit_latch) begin
      mtype_q <= hrd.mtype;
      mlen_q  <= n_cur;
      mbody_q <= body_eff;
      bidx_q  <= '0;
    end else if (cmd_i.res_byte) begin
      bidx_q  <= bidx_q + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.send_done) begin
      ost_q   <= drop_q ? tmq_pkg::ST_DROPPED : tmq_pkg::ST_STORED;
      otype_q <= stype_q;
      olen_q  <= scnt_q;
      obyte_q <= '0;
      olast_q <= 1'b1;
    end else if (cmd_i.res_nomatch) begin
      ost_q   <= tmq_pkg::ST_NOMATCH;
      otype_q <= '0;
      olen_q  <= '0;
      obyte_q <= '0;
      olast_q <= 1'b1;
    end else if (cmd_i.res_empty) begin
      ost_q   <= tmq_pkg::ST_EMPTY;
      otype_q <= mtype_q;
      olen_q  <= '0;
      obyte_q <= '0;
      olast_q <= 1'b1;
    end else if (cmd_i.res_byte) begin
      ost_q   <= tmq_pkg::ST_DATA;
      otype_q <= mtype_q;
      olen_q  <= mlen_q;
      obyte_q <= b_rdata;
      olast_q <= byte_end;
    end
  end

  assign in_i.ready     = cmd_i.in_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.status   = ost_q;
  assign out_o.msg_type = otype_q;
  assign out_o.length   = olen_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.last_res = olast_q;

  // Status to the controller
  assign sts_o.in_valid  = in_i.valid;
  assign sts_o.in_cmd    = in_i.command;
  assign sts_o.busy      = busy_q;
  assign sts_o.full      = full;
  assign sts_o.used_zero = (used_q == '0);
  assign sts_o.send_last = last_q;
  assign sts_o.match     = match;
  assign sts_o.scan_end  = (tmq_pkg::CNT_W'(idx_q) + 1'b1 >= used_q);
  assign sts_o.n_zero    = (mlen_q == '0);
  assign sts_o.out_free  = out_free;
  assign sts_o.byte_end  = byte_end;
  assign sts_o.sh_end    = (idx_q == tmq_pkg::HI_W'(tmq_pkg::SLOTS - 1));

`ifndef SYNTHESIS
  a_used_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= tmq_pkg::CNT_W'(tmq_pkg::SLOTS))
    else $error("fill count above header count");

  a_send_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> scnt_q <= tmq_pkg::LEN_W'(tmq_pkg::MSG_BYTES))
    else $error("send byte count above message size");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a pending result");

  a_byte_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.body_rd |-> bidx_q < mlen_q)
    else $error("byte read beyond delivered length");
`endif

endmodule

// ----- rtl/typed_message_queue_core.sv -----
// Typed message queue top level: controller plus datapath.
// Depends on tmq_pkg, tmq_if, tmq_ctrl, tmq_dp.
//
//  channel | dir | carries
//  in_i    | in  | send byte items (command 0) and receive requests (command 1)
//  out_o   | out | send status, no-match, empty or one byte per result item
//
// A send item writes its byte; the first item of a message that is not dropped
// also reads a header for its body slot, and the last item also loads its result.
// A receive scans headers up to the match, delivers its bytes, then shifts every
// header behind it one slot forward up to the last slot; a miss scans each stored
// header and then loads a no-match result. Each header move is a registered RAM read, then
// a write. Reset is asynchronous and needs no clearing pass. A stalled result
// holds the controller in its delivery state; in_i is ready only between items.
module typed_message_queue_core (
  input logic       clk_i,
  input logic       rst_ni,
  tmq_in_if.sink    in_i,
  tmq_out_if.source out_o
);

  tmq_pkg::cmd_t cmd;
  tmq_pkg::sts_t sts;

  tmq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tmq_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
